// ===== rtl/yss_pkg.sv =====
// Package for the YUYV nearest-neighbour scaler with RGB565 output.
// Holds shared types, constants and small arithmetic helpers.
// No dependencies; every other rtl file imports it.
`default_nettype none

package yss_pkg;

    // Dimensions and widths
    localparam int MAX_DIM  = 4096;
    localparam int DIM_W    = $clog2(MAX_DIM) + 1;
    localparam int CNT_W    = $clog2(MAX_DIM);
    localparam int DIV_CW   = $clog2(DIM_W + 1);
    localparam int Q_DEPTH  = 4;
    localparam int Q_PTR_W  = $clog2(Q_DEPTH);
    localparam int IDX_W    = 24;
    localparam int FETCH_W  = 25;
    localparam int PROD_W   = 25;
    localparam int COL_W    = 20;
    localparam int CFG_IDX_W = 3;

    // Reset values of the registers
    localparam logic [DIM_W-1:0] RST_SRC_W = DIM_W'(640);
    localparam logic [DIM_W-1:0] RST_SRC_H = DIM_W'(480);
    localparam logic [DIM_W-1:0] RST_DST_W = DIM_W'(480);
    localparam logic [DIM_W-1:0] RST_DST_H = DIM_W'(800);
    localparam logic [DIM_W-1:0] RST_PITCH = DIM_W'(480);

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_W = 3'd0,
        CFG_SRC_H = 3'd1,
        CFG_DST_W = 3'd2,
        CFG_DST_H = 3'd3,
        CFG_PITCH = 3'd4
    } t_cfg_idx;

    // Input transaction: one YUYV macropixel
    typedef struct packed {
        logic [7:0] luma_even;
        logic [7:0] chroma_u;
        logic [7:0] luma_odd;
        logic [7:0] chroma_v;
    } t_in;

    // Output transaction: one display pixel
    typedef struct packed {
        logic [15:0]        pixel_565;
        logic [IDX_W-1:0]   display_index;
        logic [FETCH_W-1:0] next_fetch_offset;
        logic               frame_end;
    } t_out;

    // Saturated frame geometry
    typedef struct packed {
        logic [DIM_W-1:0] src_w;
        logic [DIM_W-1:0] src_h;
        logic [DIM_W-1:0] dst_w;
        logic [DIM_W-1:0] dst_h;
        logic [DIM_W-1:0] pitch;
    } t_dims;

    // Scale steps: quotient and remainder per axis
    typedef struct packed {
        logic [DIM_W-1:0] col_q;
        logic [DIM_W-1:0] col_r;
        logic [DIM_W-1:0] line_q;
        logic [DIM_W-1:0] line_r;
    } t_steps;

    // Step unit status towards the front end
    typedef struct packed {
        logic   busy;
        t_steps steps;
    } t_div_stat;

    // Queue entry from front end to back end
    typedef struct packed {
        logic [7:0]       luma;
        logic [7:0]       chroma_u;
        logic [7:0]       chroma_v;
        logic [CNT_W-1:0] out_line;
        logic [CNT_W-1:0] out_column;
        logic [DIM_W-1:0] pitch;
        logic [CNT_W-1:0] src_line;
        logic [CNT_W-1:0] src_column;
        logic [DIM_W-1:0] src_w;
        logic             last;
    } t_job;

    // Back end product stage
    typedef struct packed {
        logic signed [COL_W-1:0] red_t;
        logic signed [COL_W-1:0] grn_t;
        logic signed [COL_W-1:0] blu_t;
        logic [PROD_W-1:0]       idx_prod;
        logic [PROD_W-1:0]       fetch_prod;
        logic [CNT_W-1:0]        out_column;
        logic [CNT_W-1:0]        src_column;
        logic                    last;
    } t_prod;

    // Saturate a dimension register to lo..MAX_DIM
    function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] lo);
        logic [DIM_W-1:0] res;
        if (v < lo) begin
            res = lo;
        end else if (v > DIM_W'(MAX_DIM)) begin
            res = DIM_W'(MAX_DIM);
        end else begin
            res = v;
        end
        return res;
    endfunction

    // Drop the fraction and clamp a colour term to 0..255
    function automatic logic [7:0] clamp_shift(input logic signed [COL_W-1:0] t);
        logic [COL_W-9:0] s;
        logic [7:0]       res;
        s = t[COL_W-1:8];
        if (t < 0) begin
            res = 8'h00;
        end else if (s > (COL_W-8)'(255)) begin
            res = 8'hFF;
        end else begin
            res = s[7:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/yss_div.sv =====
// Step unit: restoring divider for the column and line scale steps.
// One quotient bit per cycle on both axes at once; depends on yss_pkg.
`default_nettype none

module yss_div (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    input  wire yss_pkg::t_dims  i_dims,
    output yss_pkg::t_div_stat   o_stat
);
    import yss_pkg::*;

    logic [DIV_CW-1:0] r_cnt, n_cnt;
    logic [DIM_W-1:0]  r_col_q, n_col_q, r_col_r, n_col_r;
    logic [DIM_W-1:0]  r_line_q, n_line_q, r_line_r, n_line_r;
    logic [DIM_W:0]    w_col_t, w_line_t;

    // Shift one dividend bit into each partial remainder
    always_comb begin
        w_col_t  = {r_col_r, r_col_q[DIM_W-1]};
        w_line_t = {r_line_r, r_line_q[DIM_W-1]};
        n_cnt    = r_cnt;
        n_col_q  = r_col_q;
        n_col_r  = r_col_r;
        n_line_q = r_line_q;
        n_line_r = r_line_r;
        if (i_start) begin
            n_cnt    = DIV_CW'(DIM_W);
            n_col_q  = i_dims.src_w;
            n_col_r  = '0;
            n_line_q = i_dims.src_h;
            n_line_r = '0;
        end else if (r_cnt != '0) begin
            n_cnt = r_cnt - 1'b1;
            if (w_col_t >= {1'b0, i_dims.dst_w}) begin
                n_col_r = DIM_W'(w_col_t - {1'b0, i_dims.dst_w});
                n_col_q = {r_col_q[DIM_W-2:0], 1'b1};
            end else begin
                n_col_r = w_col_t[DIM_W-1:0];
                n_col_q = {r_col_q[DIM_W-2:0], 1'b0};
            end
            if (w_line_t >= {1'b0, i_dims.dst_h}) begin
                n_line_r = DIM_W'(w_line_t - {1'b0, i_dims.dst_h});
                n_line_q = {r_line_q[DIM_W-2:0], 1'b1};
            end else begin
                n_line_r = w_line_t[DIM_W-1:0];
                n_line_q = {r_line_q[DIM_W-2:0], 1'b0};
            end
        end
    end

    // Hold the iteration count and partial results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_col_q  <= n_col_q;
        r_col_r  <= n_col_r;
        r_line_q <= n_line_q;
        r_line_r <= n_line_r;
    end

    assign o_stat.busy         = (r_cnt != '0);
    assign o_stat.steps.col_q  = r_col_q;
    assign o_stat.steps.col_r  = r_col_r;
    assign o_stat.steps.line_q = r_line_q;
    assign o_stat.steps.line_r = r_line_r;

endmodule

`default_nettype wire

// ===== rtl/yss_front.sv =====
// Front end: register file, frame latches and raster counters.
// Accepts macropixels and pushes one job per pixel; depends on yss_pkg.
`default_nettype none

module yss_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [yss_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [yss_pkg::DIM_W-1:0]     i_cfg_data,
    input  wire logic                          i_valid,
    input  wire yss_pkg::t_in                  i_data,
    output logic                               o_stall,
    output logic                               o_div_start,
    output yss_pkg::t_dims                     o_dims,
    input  wire yss_pkg::t_div_stat            i_div,
    input  wire logic                          i_q_full,
    output logic                               o_push,
    output yss_pkg::t_job                      o_job
);
    import yss_pkg::*;

    t_dims            r_cfg;
    t_dims            r_lat_dims;
    t_steps           r_lat_steps;
    logic             r_kick;
    logic [CNT_W-1:0] r_out_col, n_out_col, r_out_line, n_out_line;
    logic [CNT_W-1:0] r_src_col, n_src_col, r_src_line, n_src_line;
    logic [CNT_W-1:0] r_col_rem, n_col_rem, r_line_rem, n_line_rem;

    t_dims            w_pre, w_dims;
    t_steps           w_steps;
    logic             w_accept, w_first, w_col_end, w_line_end;
    logic [DIM_W-1:0] w_col_pos, w_col_acc, w_col_rem;
    logic [DIM_W-1:0] w_line_pos, w_line_acc, w_line_rem;

    // Write the registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.src_w <= RST_SRC_W;
            r_cfg.src_h <= RST_SRC_H;
            r_cfg.dst_w <= RST_DST_W;
            r_cfg.dst_h <= RST_DST_H;
            r_cfg.pitch <= RST_PITCH;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_SRC_W: r_cfg.src_w <= i_cfg_data;
                CFG_SRC_H: r_cfg.src_h <= i_cfg_data;
                CFG_DST_W: r_cfg.dst_w <= i_cfg_data;
                CFG_DST_H: r_cfg.dst_h <= i_cfg_data;
                CFG_PITCH: r_cfg.pitch <= i_cfg_data;
                default:   r_cfg <= r_cfg;
            endcase
        end
    end

    // Restart the step unit after reset and after every write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kick <= 1'b1;
        end else begin
            r_kick <= i_cfg_we;
        end
    end

    // Saturate the registers
    always_comb begin
        w_pre.src_w = sat_dim(r_cfg.src_w, DIM_W'(2));
        w_pre.src_h = sat_dim(r_cfg.src_h, DIM_W'(1));
        w_pre.dst_w = sat_dim(r_cfg.dst_w, DIM_W'(1));
        w_pre.dst_h = sat_dim(r_cfg.dst_h, DIM_W'(1));
        w_pre.pitch = sat_dim(r_cfg.pitch, DIM_W'(1));
    end

    assign o_dims      = w_pre;
    assign o_div_start = r_kick;

    // Stall during a register write, while the steps are not settled or while the queue is full
    assign o_stall  = i_cfg_we || r_kick || i_div.busy || i_q_full;
    assign w_accept = i_valid && !o_stall;
    assign w_first  = (r_out_col == '0) && (r_out_line == '0);

    // At frame start use the fresh geometry, otherwise the latched one
    assign w_dims  = w_first ? w_pre : r_lat_dims;
    assign w_steps = w_first ? i_div.steps : r_lat_steps;

    always_ff @(posedge i_clk) begin
        if (w_accept && w_first) begin
            r_lat_dims  <= w_pre;
            r_lat_steps <= i_div.steps;
        end
    end

    // Advance the raster and source accumulators
    always_comb begin
        w_col_end  = ({1'b0, r_out_col} + 1'b1) >= w_dims.dst_w;
        w_line_end = ({1'b0, r_out_line} + 1'b1) >= w_dims.dst_h;
        w_col_pos  = {1'b0, r_src_col} + w_steps.col_q;
        w_col_acc  = {1'b0, r_col_rem} + w_steps.col_r;
        w_line_pos = {1'b0, r_src_line} + w_steps.line_q;
        w_line_acc = {1'b0, r_line_rem} + w_steps.line_r;
        if (w_col_acc >= w_dims.dst_w) begin
            w_col_rem = w_col_acc - w_dims.dst_w;
            w_col_pos = w_col_pos + 1'b1;
        end else begin
            w_col_rem = w_col_acc;
        end
        if (w_line_acc >= w_dims.dst_h) begin
            w_line_rem = w_line_acc - w_dims.dst_h;
            w_line_pos = w_line_pos + 1'b1;
        end else begin
            w_line_rem = w_line_acc;
        end

        n_out_col  = r_out_col;
        n_src_col  = r_src_col;
        n_col_rem  = r_col_rem;
        n_out_line = r_out_line;
        n_src_line = r_src_line;
        n_line_rem = r_line_rem;
        if (!w_col_end) begin
            n_out_col = r_out_col + 1'b1;
            n_src_col = w_col_pos[CNT_W-1:0];
            n_col_rem = w_col_rem[CNT_W-1:0];
        end else begin
            n_out_col = '0;
            n_src_col = '0;
            n_col_rem = '0;
            if (!w_line_end) begin
                n_out_line = r_out_line + 1'b1;
                n_src_line = w_line_pos[CNT_W-1:0];
                n_line_rem = w_line_rem[CNT_W-1:0];
            end else begin
                n_out_line = '0;
                n_src_line = '0;
                n_line_rem = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_col  <= '0;
            r_out_line <= '0;
            r_src_col  <= '0;
            r_src_line <= '0;
            r_col_rem  <= '0;
            r_line_rem <= '0;
        end else if (w_accept) begin
            r_out_col  <= n_out_col;
            r_out_line <= n_out_line;
            r_src_col  <= n_src_col;
            r_src_line <= n_src_line;
            r_col_rem  <= n_col_rem;
            r_line_rem <= n_line_rem;
        end
    end

    // Pick the luma by source column parity and build the job
    assign o_push              = w_accept;
    assign o_job.luma          = r_src_col[0] ? i_data.luma_odd : i_data.luma_even;
    assign o_job.chroma_u      = i_data.chroma_u;
    assign o_job.chroma_v      = i_data.chroma_v;
    assign o_job.out_line      = r_out_line;
    assign o_job.out_column    = r_out_col;
    assign o_job.pitch         = w_dims.pitch;
    assign o_job.src_line      = n_src_line;
    assign o_job.src_column    = n_src_col;
    assign o_job.src_w         = w_dims.src_w;
    assign o_job.last          = w_col_end && w_line_end;

endmodule

`default_nettype wire

// ===== rtl/yss_queue.sv =====
// Job queue between front end and back end, a few entries in flip-flops.
// Depends on yss_pkg for the entry type and depth.
`default_nettype none

module yss_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire yss_pkg::t_job i_job,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_empty,
    output yss_pkg::t_job      o_head
);
    import yss_pkg::*;

    t_job               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [Q_PTR_W:0]   r_count;
    logic               w_push, w_pop;

    assign o_full  = (r_count == (Q_PTR_W+1)'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_head  = r_mem[r_rd_ptr];

    // Store the pushed entry
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // Advance the pointers and the fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/yss_back.sv =====
// Back end: BT.601 colour conversion, RGB565 packing and address products.
// Two registered stages, the product register and the output register; depends on yss_pkg.
`default_nettype none

module yss_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_empty,
    input  wire yss_pkg::t_job i_head,
    output logic               o_pop,
    output logic               o_valid,
    output yss_pkg::t_out      o_data,
    input  wire logic          i_stall
);
    import yss_pkg::*;

    logic                    r_v1, r_v2;
    t_prod                   r_s1, n_s1;
    t_out                    r_out, n_out;
    logic                    w_adv2, w_adv1;
    logic signed [9:0]       w_c, w_d, w_e;
    logic [7:0]              w_red, w_grn, w_blu;
    logic [PROD_W-1:0]       w_idx_sum, w_fetch_sum;

    // Each stage moves when the one after it is empty or moving
    assign w_adv2 = !r_v2 || !i_stall;
    assign w_adv1 = !r_v1 || w_adv2;
    assign o_pop  = !i_empty && w_adv1;

    // Stage one: constant multiplies and the two address products
    always_comb begin
        w_c = $signed({2'b00, i_head.luma}) - 10'sd16;
        w_d = $signed({2'b00, i_head.chroma_u}) - 10'sd128;
        w_e = $signed({2'b00, i_head.chroma_v}) - 10'sd128;
        n_s1.red_t = COL_W'(298) * COL_W'(w_c) + COL_W'(409) * COL_W'(w_e)
                   + COL_W'(128);
        n_s1.grn_t = COL_W'(298) * COL_W'(w_c) - COL_W'(100) * COL_W'(w_d)
                   - COL_W'(208) * COL_W'(w_e) + COL_W'(128);
        n_s1.blu_t = COL_W'(298) * COL_W'(w_c) + COL_W'(516) * COL_W'(w_d)
                   + COL_W'(128);
        n_s1.idx_prod   = PROD_W'(i_head.out_line) * PROD_W'(i_head.pitch);
        n_s1.fetch_prod = PROD_W'(i_head.src_line) * PROD_W'(i_head.src_w);
        n_s1.out_column = i_head.out_column;
        n_s1.src_column = i_head.src_column;
        n_s1.last       = i_head.last;
    end

    // Stage two: clamp, pack and finish the addresses
    always_comb begin
        w_red       = clamp_shift(r_s1.red_t);
        w_grn       = clamp_shift(r_s1.grn_t);
        w_blu       = clamp_shift(r_s1.blu_t);
        w_idx_sum   = r_s1.idx_prod + PROD_W'(r_s1.out_column);
        w_fetch_sum = r_s1.fetch_prod + PROD_W'(r_s1.src_column);
        n_out.pixel_565         = {w_red[7:3], w_grn[7:2], w_blu[7:3]};
        n_out.display_index     = w_idx_sum[IDX_W-1:0];
        n_out.next_fetch_offset = {w_fetch_sum[FETCH_W-2:1], 2'b00};
        n_out.frame_end         = r_s1.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_adv1) begin
                r_v1 <= !i_empty;
            end
            if (w_adv2) begin
                r_v2 <= r_v1;
            end
        end
        if (o_pop) begin
            r_s1 <= n_s1;
        end
        if (w_adv2 && r_v1) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_v2;
    assign o_data  = r_out;

endmodule

`default_nettype wire

// ===== rtl/yuyv_scale_to_rgb565_unit.sv =====
// Top level of the YUYV nearest-neighbour scaler with RGB565 output.
// Instantiates yss_front, yss_div, yss_queue and yss_back; uses yss_pkg.
//
// Usage:
//  - Register port: i_cfg_we, i_cfg_index, i_cfg_data write source width and
//    height, target width and height and display pitch (indexes 0..4). Values
//    are saturated and take effect at the next frame start.
//  - Input channel (i_valid, i_data, o_stall): one YUYV macropixel per output
//    pixel, the one named by the previous result's next_fetch_offset
//    (offset 0 for the first pixel of a frame).
//  - Output channel (o_valid, o_data, i_stall): pixel, framebuffer index,
//    next fetch offset and a frame end flag, one result per macropixel.
//  - Throughput is one pixel per clock when no stall holds the flow. From input
//    to output a pixel passes the queue entry, product stage, output register.
//  - After reset and after each register write the scale steps are worked out
//    by a bit-serial divider; o_stall stays high meanwhile.
//  - A stall on the output fills the four-entry queue, then raises o_stall.
//    Reset returns the raster to the first pixel of a frame.
`default_nettype none

module yuyv_scale_to_rgb565_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [yss_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [yss_pkg::DIM_W-1:0]     i_cfg_data,
    input  wire logic                          i_valid,
    input  wire yss_pkg::t_in                  i_data,
    output logic                               o_stall,
    output logic                               o_valid,
    output yss_pkg::t_out                      o_data,
    input  wire logic                          i_stall
);
    import yss_pkg::*;

    logic      w_div_start;
    t_dims     w_dims;
    t_div_stat w_div;
    logic      w_push, w_full, w_pop, w_empty;
    t_job      w_job, w_head;

    yss_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .i_data      (i_data),
        .o_stall     (o_stall),
        .o_div_start (w_div_start),
        .o_dims      (w_dims),
        .i_div       (w_div),
        .i_q_full    (w_full),
        .o_push      (w_push),
        .o_job       (w_job)
    );

    yss_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_dims  (w_dims),
        .o_stat  (w_div)
    );

    yss_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    yss_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_valid (o_valid),
        .o_data  (o_data),
        .i_stall (i_stall)
    );

`ifndef SYNTHESIS
    // No job enters a full queue
    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("job pushed into a full queue");

    // No job leaves an empty queue
    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty)
        else $error("job popped from an empty queue");

    // No pixel is taken while the scale steps are being worked out
    a_no_push_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_div.busy || w_div_start) |-> !w_push)
        else $error("pixel accepted while the divider is busy");

    // The last pixel of a frame points the fetch back at the frame start
    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.frame_end) |-> (o_data.next_fetch_offset == '0))
        else $error("frame end without fetch offset wrap");
`endif

endmodule

`default_nettype wire

// ===== sim/yuyv_scale_to_rgb565_unit_tb.sv =====
// Self-checking testbench for yuyv_scale_to_rgb565_unit: register phases with
// small output frames, random macropixels, random idle and stall on both sides.
// Depends on yss_pkg and the rtl of yuyv_scale_to_rgb565_unit.
module yuyv_scale_to_rgb565_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import yss_pkg::*;

    localparam int CFG_COUNT   = 5;
    localparam int QUIET_LIMIT = 4000;
    localparam int PHASES      = 22;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DIM_W-1:0]     cfg_data = '0;
    logic                 drv_valid = 1'b0;
    t_in                  drv_data = '0;
    logic                 sink_stall = 1'b0;
    logic                 o_stall;
    logic                 o_valid;
    t_out                 o_data;

    // Macropixels waiting to be sent and pixels still owed by the block
    t_in  pending[$];
    t_out pixel_due[$];
    t_out want;

    int idle_pct = 31;
    int stall_pct = 31;
    int fail_count = 0;
    int quiet_cycles = 0;

    // Predictor state: register file, latched geometry, raster and source walk
    logic [DIM_W-1:0] cfg_reg [0:CFG_COUNT-1];
    logic [DIM_W-1:0] geo_sw, geo_sh, geo_tw, geo_th, geo_pitch;
    logic [DIM_W-1:0] col_q, col_r, line_q, line_r;
    logic [CNT_W-1:0] ras_col = '0, ras_line = '0, src_col = '0, src_line = '0;
    logic [DIM_W-1:0] src_col_frac = '0, src_line_frac = '0;

    yuyv_scale_to_rgb565_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_valid     (drv_valid),
        .i_data      (drv_data),
        .o_stall     (o_stall),
        .o_valid     (o_valid),
        .o_data      (o_data),
        .i_stall     (sink_stall)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic logic [DIM_W-1:0] clip_dim(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W-1:0] lo);
        if (v < lo) return lo;
        if (v > DIM_W'(MAX_DIM)) return DIM_W'(MAX_DIM);
        return v;
    endfunction

    // Drop the eight fraction bits and clamp to a byte
    function automatic logic [7:0] to_channel(input int t);
        if (t < 0) return 8'd0;
        t = t >>> 8;
        return (t > 255) ? 8'd255 : t[7:0];
    endfunction

    // Work out the pixel for one macropixel and step the raster
    function automatic t_out scale_pixel(input t_in px);
        logic [7:0] luma;
        logic [7:0] r8, g8, b8;
        int         c, d, e;
        logic [31:0] addr;
        t_out       res;
        if (ras_col == 0 && ras_line == 0) begin
            geo_sw    = clip_dim(cfg_reg[CFG_SRC_W], 2);
            geo_sh    = clip_dim(cfg_reg[CFG_SRC_H], 1);
            geo_tw    = clip_dim(cfg_reg[CFG_DST_W], 1);
            geo_th    = clip_dim(cfg_reg[CFG_DST_H], 1);
            geo_pitch = clip_dim(cfg_reg[CFG_PITCH], 1);
            col_q  = geo_sw / geo_tw;
            col_r  = geo_sw % geo_tw;
            line_q = geo_sh / geo_th;
            line_r = geo_sh % geo_th;
        end
        luma = src_col[0] ? px.luma_odd : px.luma_even;
        c = int'(luma) - 16;
        d = int'(px.chroma_u) - 128;
        e = int'(px.chroma_v) - 128;
        r8 = to_channel(298 * c + 409 * e + 128);
        g8 = to_channel(298 * c - 100 * d - 208 * e + 128);
        b8 = to_channel(298 * c + 516 * d + 128);
        res.pixel_565 = {r8[7:3], g8[7:2], b8[7:3]};
        res.display_index = IDX_W'(32'(ras_line) * 32'(geo_pitch) + 32'(ras_col));
        res.frame_end = (32'(ras_col) + 1 >= 32'(geo_tw)) &&
                        (32'(ras_line) + 1 >= 32'(geo_th));

        // Advance along the line, or wrap to the next line or frame
        if (32'(ras_col) + 1 < 32'(geo_tw)) begin
            ras_col = ras_col + 1'b1;
            src_col = src_col + CNT_W'(col_q);
            src_col_frac = src_col_frac + col_r;
            if (src_col_frac >= geo_tw) begin
                src_col_frac = src_col_frac - geo_tw;
                src_col = src_col + 1'b1;
            end
        end else begin
            ras_col = '0;
            src_col = '0;
            src_col_frac = '0;
            if (32'(ras_line) + 1 < 32'(geo_th)) begin
                ras_line = ras_line + 1'b1;
                src_line = src_line + CNT_W'(line_q);
                src_line_frac = src_line_frac + line_r;
                if (src_line_frac >= geo_th) begin
                    src_line_frac = src_line_frac - geo_th;
                    src_line = src_line + 1'b1;
                end
            end else begin
                ras_line = '0;
                src_line = '0;
                src_line_frac = '0;
            end
        end
        addr = (32'(src_line) * 32'(geo_sw) + 32'(src_col)) & ~32'd1;
        res.next_fetch_offset = FETCH_W'(addr * 2);
        return res;
    endfunction

    // Width, height or pitch: mostly in range, sometimes beyond either end
    function automatic logic [DIM_W-1:0] pick_span();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return DIM_W'(1);
            2: return DIM_W'(MAX_DIM);
            3: return DIM_W'($urandom_range(MAX_DIM + 1, (1 << DIM_W) - 1));
            4, 5: return DIM_W'($urandom_range(2, MAX_DIM));
            default: return DIM_W'($urandom_range(2, 48));
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [DIM_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx < CFG_COUNT) cfg_reg[idx] = val;
    endtask

    // Write the registers picked by the mask, plus an optional stray index
    task automatic load_geometry(input logic [DIM_W-1:0] sw, input logic [DIM_W-1:0] sh,
                                 input logic [DIM_W-1:0] tw, input logic [DIM_W-1:0] th,
                                 input logic [DIM_W-1:0] pitch,
                                 input logic [CFG_COUNT-1:0] mask, input logic stray);
        if (mask[CFG_SRC_W]) write_reg(CFG_SRC_W, sw);
        if (mask[CFG_SRC_H]) write_reg(CFG_SRC_H, sh);
        if (mask[CFG_DST_W]) write_reg(CFG_DST_W, tw);
        if (mask[CFG_DST_H]) write_reg(CFG_DST_H, th);
        if (mask[CFG_PITCH]) write_reg(CFG_PITCH, pitch);
        if (stray) begin
            write_reg(CFG_IDX_W'($urandom_range(CFG_COUNT, (1 << CFG_IDX_W) - 1)),
                      DIM_W'($urandom));
        end
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Hold until every queued transaction has gone through and come back
    task automatic wait_drained();
        do @(negedge clk);
        while (pending.size() != 0 || drv_valid || pixel_due.size() != 0);
    endtask

    // Driver: predict on acceptance, then load the next transaction or idle
    always @(posedge clk) begin
        if (!rst_n) begin
            drv_valid <= 1'b0;
        end else begin
            if (drv_valid && !o_stall) begin
                pixel_due.push_back(scale_pixel(drv_data));
            end
            if (!drv_valid || !o_stall) begin
                if (pending.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                    drv_valid <= 1'b1;
                    drv_data  <= pending.pop_front();
                end else begin
                    drv_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver back-pressure
    always @(posedge clk) begin
        sink_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Monitor: compare each output transaction with the oldest prediction
    always @(posedge clk) begin
        if (rst_n && o_valid && !sink_stall) begin
            if (pixel_due.size() == 0) begin
                $error("unexpected pixel %h at index %h", o_data.pixel_565,
                       o_data.display_index);
                fail_count++;
            end else begin
                want = pixel_due.pop_front();
                if (o_data.pixel_565 !== want.pixel_565) begin
                    $error("pixel_565: expected %h, got %h", want.pixel_565,
                           o_data.pixel_565);
                    fail_count++;
                end
                if (o_data.display_index !== want.display_index) begin
                    $error("display_index: expected %h, got %h", want.display_index,
                           o_data.display_index);
                    fail_count++;
                end
                if (o_data.next_fetch_offset !== want.next_fetch_offset) begin
                    $error("next_fetch_offset: expected %h, got %h",
                           want.next_fetch_offset, o_data.next_fetch_offset);
                    fail_count++;
                end
                if (o_data.frame_end !== want.frame_end) begin
                    $error("frame_end: expected %b, got %b", want.frame_end,
                           o_data.frame_end);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: end the run if nothing moves for too long
    always @(posedge clk) begin
        if ((drv_valid && !o_stall) || (o_valid && !sink_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Stimulus: directed frame, random register phases, one oversized frame
    initial begin
        logic [DIM_W-1:0] tw, th;
        int               count;
        int               frame_left;
        cfg_reg[CFG_SRC_W] = RST_SRC_W;
        cfg_reg[CFG_SRC_H] = RST_SRC_H;
        cfg_reg[CFG_DST_W] = RST_DST_W;
        cfg_reg[CFG_DST_H] = RST_DST_H;
        cfg_reg[CFG_PITCH] = RST_PITCH;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Upscale by two across so both luma bytes get picked; clamp extremes
        load_geometry(DIM_W'(4), DIM_W'(2), DIM_W'(8), DIM_W'(2), DIM_W'(9), '1, 1'b0);
        @(negedge clk);
        pending.push_back(t_in'(32'h00_00_00_00));
        pending.push_back(t_in'(32'hFF_FF_FF_FF));
        pending.push_back(t_in'(32'h10_80_10_80));
        pending.push_back(t_in'(32'hEB_80_EB_80));
        pending.push_back(t_in'(32'hFF_00_00_FF));
        pending.push_back(t_in'(32'h00_FF_FF_00));
        pending.push_back(t_in'(32'h10_80_EB_80));
        pending.push_back(t_in'(32'hEB_80_10_80));
        pending.push_back(t_in'(32'h51_5A_51_F0));
        pending.push_back(t_in'(32'h29_F0_29_6E));
        pending.push_back(t_in'(32'h91_36_91_22));
        pending.push_back(t_in'(32'hFF_FF_00_00));
        pending.push_back(t_in'(32'h00_00_FF_FF));
        pending.push_back(t_in'(32'h80_00_80_00));
        pending.push_back(t_in'(32'h80_FF_80_FF));
        pending.push_back(t_in'(32'h7F_80_80_7F));
        pending.push_back(t_in'(32'h10_00_10_00));
        pending.push_back(t_in'(32'hEB_FF_EB_FF));

        for (int phase = 0; phase < PHASES; phase++) begin
            wait_drained();
            // Run a few phases flat out on both sides
            idle_pct  = (phase >= 6 && phase < 9) ? 0 : 31;
            stall_pct = (phase >= 6 && phase < 9) ? 0 : 31;
            case ($urandom_range(0, 9))
                0: tw = '0;
                1: tw = DIM_W'($urandom_range(17, 48));
                default: tw = DIM_W'($urandom_range(1, 12));
            endcase
            th = ($urandom_range(0, 9) == 0) ? '0 : DIM_W'($urandom_range(1, 10));
            load_geometry(pick_span(), pick_span(), tw, th, pick_span(),
                          CFG_COUNT'($urandom), ($urandom_range(0, 3) == 0));
            count = $urandom_range(25, 95);
            @(negedge clk);
            for (int k = 0; k < count; k++) begin
                // Hold off the sender mid-phase until the block has emptied
                if (phase % 2 == 1 && k == count / 2) wait_drained();
                pending.push_back(t_in'($urandom));
            end
        end

        // Largest geometry: finish the current frame, then run into the big one
        wait_drained();
        frame_left = (ras_col == 0 && ras_line == 0) ? 0 :
                     (int'(geo_th) - int'(ras_line)) * int'(geo_tw) - int'(ras_col);
        load_geometry('1, DIM_W'(MAX_DIM), '1, DIM_W'(MAX_DIM), '1, '1, 1'b1);
        @(negedge clk);
        for (int k = 0; k < frame_left + 120; k++) begin
            pending.push_back(t_in'($urandom));
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
